>>> rtl/core/mhog_pkg.sv
// shared types, widths and tables of the masked orientation histogram
package mhog_pkg;

    // pixel and gradient widths
    localparam int PIX_W   = 8;
    localparam int GRAD_W  = PIX_W + 3;
    localparam int SUM_W   = 2 * GRAD_W;
    localparam int SQ_W    = SUM_W + 8;
    localparam int MAG_W   = SQ_W / 2;
    localparam int ANG_W   = 16;
    localparam int XY_W    = GRAD_W + 11;
    localparam int CORDIC_STEPS = 14;
    localparam int SQRT_STEPS   = SQ_W / 2;
    localparam int STEP_W  = 4;

    // histogram word
    localparam int VAL_W = 27;
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
    localparam int IDX_W = 4;
    localparam int OUT_W = 32;

    // configuration registers
    localparam int CFG_W = 7;
    localparam logic [0:0] REG_CELL_WIDTH  = 1'b0;
    localparam logic [0:0] REG_CELL_HEIGHT = 1'b1;

    localparam logic [ANG_W-1:0] HALF_TURN = 16'h8000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_VEC,
        ST_MUL,
        ST_BRD,
        ST_BWR,
        ST_NEXT,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [ANG_W-1:0] angle;
    } vec_res_t;

    // arctangent of 2^-i as a fraction of a full turn
    function automatic logic [ANG_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [ANG_W-1:0] v;
        case (i)
            4'd0:    v = 16'd8192;
            4'd1:    v = 16'd4836;
            4'd2:    v = 16'd2555;
            4'd3:    v = 16'd1297;
            4'd4:    v = 16'd651;
            4'd5:    v = 16'd326;
            4'd6:    v = 16'd163;
            4'd7:    v = 16'd81;
            4'd8:    v = 16'd41;
            4'd9:    v = 16'd20;
            4'd10:   v = 16'd10;
            4'd11:   v = 16'd5;
            4'd12:   v = 16'd3;
            4'd13:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/mhog_vec.sv
// iterative magnitude (bit-serial square root) and orientation (cordic) unit
module mhog_vec (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [mhog_pkg::GRAD_W-1:0] dx,
    input  logic signed [mhog_pkg::GRAD_W-1:0] dy,
    output logic                                done,
    output mhog_pkg::vec_res_t                  res
);

    localparam int SQ_W = mhog_pkg::SQ_W;
    localparam int XY_W = mhog_pkg::XY_W;

    logic                              ld_reg, ld_next;
    logic                              run_reg, run_next;
    logic                              done_reg, done_next;
    logic [mhog_pkg::STEP_W-1:0]       cnt_reg, cnt_next;

    logic [mhog_pkg::SUM_W-1:0]        sqx_reg, sqx_next;
    logic [mhog_pkg::SUM_W-1:0]        sqy_reg, sqy_next;
    logic [SQ_W-1:0]                   n_reg, n_next;
    logic [SQ_W-1:0]                   root_reg, root_next;
    logic [SQ_W-1:0]                   bit_reg, bit_next;
    logic signed [XY_W-1:0]            x_reg, x_next;
    logic signed [XY_W-1:0]            y_reg, y_next;
    logic [mhog_pkg::ANG_W-1:0]        z_reg, z_next;

    logic signed [XY_W-1:0]            x0, y0, xs, ys;
    logic [SQ_W-1:0]                   trial;

    // sequencing and datapath next values
    always_comb
    begin
        ld_next   = 1'b0;
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sqx_next  = sqx_reg;
        sqy_next  = sqy_reg;
        n_next    = n_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;

        x0 = -(XY_W'(dx) <<< 8);
        y0 = -(XY_W'(dy) <<< 8);
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        trial = root_reg + bit_reg;

        if (start)
        begin
            // squares and the half-plane fold
            sqx_next = $unsigned(mhog_pkg::SUM_W'(dx) * mhog_pkg::SUM_W'(dx));
            sqy_next = $unsigned(mhog_pkg::SUM_W'(dy) * mhog_pkg::SUM_W'(dy));
            ld_next  = 1'b1;
            if (x0 < 0)
            begin
                x_next = -x0;
                y_next = -y0;
                z_next = mhog_pkg::HALF_TURN;
            end
            else
            begin
                x_next = x0;
                y_next = y0;
                z_next = '0;
            end
        end
        else if (ld_reg)
        begin
            n_next    = {mhog_pkg::SUM_W'(sqx_reg + sqy_reg), 8'd0};
            root_next = '0;
            bit_next  = SQ_W'(1) << (SQ_W - 2);
            cnt_next  = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            // one root bit per cycle
            if (n_reg >= trial)
            begin
                n_next    = n_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;

            // one cordic rotation per cycle
            if (cnt_reg < mhog_pkg::STEP_W'(mhog_pkg::CORDIC_STEPS))
            begin
                if (!y_reg[XY_W-1])
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + mhog_pkg::atan_turn(cnt_reg);
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - mhog_pkg::atan_turn(cnt_reg);
                end
            end

            if (cnt_reg == mhog_pkg::STEP_W'(mhog_pkg::SQRT_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_reg   <= 1'b0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            ld_reg   <= ld_next;
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        n_reg    <= n_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign done      = done_reg;
    assign res.mag   = root_reg[mhog_pkg::MAG_W-1:0];
    assign res.angle = z_reg;

endmodule

>>> rtl/core/masked_hog_histogram.sv
// top level: line stores, per-row gradient pass and orientation histogram
//
// Pixels come in on the s_ channel in raster order, one word per pixel with
// the mask bit on s_tuser; cell_width words make a row, cell_height rows a
// cell. Sizes are set on the cfg_ channel (index 0 width, 1 height, clamped
// to 2..MAX); the user must set them only while the block is idle, and the
// block itself does not enforce this. Within a row a pixel is taken every
// cycle. After the last pixel of each row from the second row on, s_tready
// drops while the previous row is swept column by column: eight line store
// reads and one step per column, plus for a masked pixel the square root
// and cordic unit, weight multiply and two read-modify-write updates of the
// bin memory. The last row of a cell gets a second sweep, then the bins
// leave on the m_ channel, one word per bin, tlast on the final bin, and
// each bin is cleared as it is read. A stalled receiver holds the current
// word in the output register and the emission waits. Reset clears
// counters, bins and handshakes; line store contents are not cleared.
module masked_hog_histogram #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int BINS       = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mhog_pkg::PIX_W-1:0]     s_tdata,   // pixel
    input  logic                           s_tuser,   // mask_bit
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mhog_pkg::OUT_W-1:0]     m_tdata,   // bin_index[3:0], bin_value[30:4]
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [0:0]                     cfg_index,
    input  logic [mhog_pkg::CFG_W-1:0]     cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int BB  = $clog2(BINS);
    localparam int WCL = (CW + 1 > mhog_pkg::CFG_W) ? CW + 1 : mhog_pkg::CFG_W;
    localparam int HCL = (RW + 1 > mhog_pkg::CFG_W) ? RW + 1 : mhog_pkg::CFG_W;
    localparam int PIX_W = mhog_pkg::PIX_W;
    localparam int VAL_W = mhog_pkg::VAL_W;
    localparam int MAG_W = mhog_pkg::MAG_W;
    localparam int ANG_W = mhog_pkg::ANG_W;
    localparam int PW    = ANG_W + BB;

    // state and configuration
    mhog_pkg::state_t                state_reg, state_next;
    logic [mhog_pkg::CFG_W-1:0]      cw_reg, cw_next;
    logic [mhog_pkg::CFG_W-1:0]      ch_reg, ch_next;
    logic [CW-1:0]                   col_reg, col_next;
    logic [RW-1:0]                   row_reg, row_next;
    logic [1:0]                      in_bank_reg, in_bank_next;
    logic [1:0]                      new_bank_reg, new_bank_next;
    logic [1:0]                      old_bank_reg, old_bank_next;
    logic                            inm_reg, inm_next;
    logic                            dm_reg, dm_next;

    // row sweep
    logic [1:0]                      up_reg, up_next;
    logic [1:0]                      mid_reg, mid_next;
    logic [1:0]                      dn_reg, dn_next;
    logic                            pm_reg, pm_next;
    logic                            final_reg, final_next;
    logic [CW-1:0]                   pc_reg, pc_next;
    logic [CW:0]                     pw_reg, pw_next;
    logic [3:0]                      k_reg, k_next;
    logic [PIX_W-1:0]                tap_reg [7];
    logic                            side_reg, side_next;
    logic [BB-1:0]                   eb_reg, eb_next;

    // binning payload
    logic [BB-1:0]                   prim_reg, prim_next;
    logic [BB-1:0]                   sec_reg, sec_next;
    logic [ANG_W-1:0]                d_reg, d_next;
    logic [MAG_W-1:0]                mag_reg, mag_next;
    logic [MAG_W-1:0]                share_reg, share_next;

    // output register
    logic                            ov_reg, ov_next;
    logic [mhog_pkg::OUT_W-1:0]      od_reg, od_next;
    logic                            ol_reg, ol_next;

    // memories
    logic [PIX_W-1:0]                pix_mem [4 << CW];
    logic                            pix_we, pix_re;
    logic [CW+1:0]                   pix_wa, pix_ra;
    logic [PIX_W-1:0]                pix_rd_reg;
    logic                            msk_mem [2 << CW];
    logic                            msk_we, msk_re;
    logic [CW:0]                     msk_wa, msk_ra;
    logic                            msk_rd_reg;
    logic [VAL_W-1:0]                bin_mem [BINS];
    logic [BINS-1:0]                 bin_ok_reg;
    logic                            bin_we, bin_re;
    logic [BB-1:0]                   bin_wa, bin_ra;
    logic [VAL_W-1:0]                bin_wd;
    logic [VAL_W-1:0]                bin_rd_reg;
    logic                            bin_rok_reg;

    // helpers
    logic [CW:0]                     w_use;
    logic [RW:0]                     h_use;
    logic [WCL-1:0]                  cw_ext;
    logic [HCL-1:0]                  ch_ext;
    logic                            in_acc;
    logic [CW-1:0]                   l_col, r_col, k_col;
    logic [1:0]                      k_bank;
    logic [PIX_W+1:0]                s_l, s_r, s_u, s_d;
    logic signed [mhog_pkg::GRAD_W-1:0] gdx, gdy;
    logic                            vec_start, vec_done;
    mhog_pkg::vec_res_t              vec_res;
    logic [PW-1:0]                   pbin;
    logic [ANG_W-1:0]                frac;
    logic [MAG_W+ANG_W-1:0]          prod;
    logic [VAL_W-1:0]                cur_val;
    logic [VAL_W:0]                  sum;
    logic [MAG_W-1:0]                addend;

    mhog_vec u_vec (
        .clk   (clk),
        .rst_n (rst_n),
        .start (vec_start),
        .dx    (gdx),
        .dy    (gdy),
        .done  (vec_done),
        .res   (vec_res)
    );

    // clamped cell size
    always_comb
    begin
        cw_ext = WCL'(cw_reg);
        ch_ext = HCL'(ch_reg);
        if (cw_ext < WCL'(2))
            w_use = (CW+1)'(2);
        else if (cw_ext > WCL'(MAX_WIDTH))
            w_use = (CW+1)'(MAX_WIDTH);
        else
            w_use = (CW+1)'(cw_ext);
        if (ch_ext < HCL'(2))
            h_use = (RW+1)'(2);
        else if (ch_ext > HCL'(MAX_HEIGHT))
            h_use = (RW+1)'(MAX_HEIGHT);
        else
            h_use = (RW+1)'(ch_ext);
    end

    // reflect-101 neighbor columns and fetch address
    always_comb
    begin
        l_col = (pc_reg == '0) ? CW'(1) : pc_reg - 1'b1;
        r_col = ((CW+1)'(pc_reg) + 1'b1 < pw_reg) ? pc_reg + 1'b1 : CW'(pw_reg - 2'd2);
        case (k_reg)
            4'd0, 4'd3, 4'd5: k_col = l_col;
            4'd1, 4'd6:       k_col = pc_reg;
            default:          k_col = r_col;
        endcase
        if (k_reg < 4'd3)
            k_bank = up_reg;
        else if (k_reg < 4'd5)
            k_bank = mid_reg;
        else
            k_bank = dn_reg;
    end

    // sobel sums; the lower right tap comes straight from the store
    always_comb
    begin
        s_l = (PIX_W+2)'(tap_reg[0]) + ((PIX_W+2)'(tap_reg[3]) << 1) + (PIX_W+2)'(tap_reg[5]);
        s_r = (PIX_W+2)'(tap_reg[2]) + ((PIX_W+2)'(tap_reg[4]) << 1) + (PIX_W+2)'(pix_rd_reg);
        s_u = (PIX_W+2)'(tap_reg[0]) + ((PIX_W+2)'(tap_reg[1]) << 1) + (PIX_W+2)'(tap_reg[2]);
        s_d = (PIX_W+2)'(tap_reg[5]) + ((PIX_W+2)'(tap_reg[6]) << 1) + (PIX_W+2)'(pix_rd_reg);
        gdx = $signed(mhog_pkg::GRAD_W'(s_r)) - $signed(mhog_pkg::GRAD_W'(s_l));
        gdy = $signed(mhog_pkg::GRAD_W'(s_d)) - $signed(mhog_pkg::GRAD_W'(s_u));
    end

    // bin split arithmetic
    always_comb
    begin
        pbin    = PW'(vec_res.angle) * PW'(BINS);
        frac    = pbin[ANG_W-1:0];
        prod    = (MAG_W+ANG_W)'(mag_reg) * (MAG_W+ANG_W)'(d_reg);
        cur_val = bin_rok_reg ? bin_rd_reg : '0;
        addend  = side_reg ? share_reg : mag_reg - share_reg;
        sum     = (VAL_W+1)'(cur_val) + (VAL_W+1)'(addend);
    end

    assign in_acc    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == mhog_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign vec_start = (state_reg == mhog_pkg::ST_FETCH) && (k_reg == 4'd8) && msk_rd_reg;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cw_next       = cw_reg;
        ch_next       = ch_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        in_bank_next  = in_bank_reg;
        new_bank_next = new_bank_reg;
        old_bank_next = old_bank_reg;
        inm_next      = inm_reg;
        dm_next       = dm_reg;
        up_next       = up_reg;
        mid_next      = mid_reg;
        dn_next       = dn_reg;
        pm_next       = pm_reg;
        final_next    = final_reg;
        pc_next       = pc_reg;
        pw_next       = pw_reg;
        k_next        = k_reg;
        side_next     = side_reg;
        eb_next       = eb_reg;
        prim_next     = prim_reg;
        sec_next      = sec_reg;
        d_next        = d_reg;
        mag_next      = mag_reg;
        share_next    = share_reg;
        ov_next       = ov_reg && !m_tready;
        od_next       = od_reg;
        ol_next       = ol_reg;

        pix_we = 1'b0;
        pix_wa = {in_bank_reg, col_reg};
        pix_re = 1'b0;
        pix_ra = {k_bank, k_col};
        msk_we = 1'b0;
        msk_wa = {inm_reg, col_reg};
        msk_re = 1'b0;
        msk_ra = {pm_reg, pc_reg};
        bin_we = 1'b0;
        bin_wa = side_reg ? sec_reg : prim_reg;
        bin_wd = sum[VAL_W] ? mhog_pkg::VAL_MAX : sum[VAL_W-1:0];
        bin_re = 1'b0;
        bin_ra = side_reg ? sec_reg : prim_reg;

        // configuration writes
        if (cfg_valid)
        begin
            case (cfg_index)
                mhog_pkg::REG_CELL_WIDTH:  cw_next = cfg_data;
                mhog_pkg::REG_CELL_HEIGHT: ch_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            mhog_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    pix_we = 1'b1;
                    msk_we = 1'b1;
                    if ((CW+1)'(col_reg) + 1'b1 < w_use)
                    begin
                        col_next = col_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = '0;
                        pw_next  = w_use;
                        if (row_reg != '0)
                        begin
                            up_next    = (row_reg == RW'(1)) ? in_bank_reg : old_bank_reg;
                            mid_next   = new_bank_reg;
                            dn_next    = in_bank_reg;
                            pm_next    = dm_reg;
                            final_next = 1'b0;
                            pc_next    = '0;
                            k_next     = '0;
                            state_next = mhog_pkg::ST_FETCH;
                        end
                        else
                        begin
                            old_bank_next = new_bank_reg;
                            new_bank_next = in_bank_reg;
                            in_bank_next  = old_bank_reg;
                            dm_next       = inm_reg;
                            inm_next      = dm_reg;
                            row_next      = RW'(1);
                        end
                    end
                end
            end

            mhog_pkg::ST_FETCH:
            begin
                if (k_reg < 4'd8)
                    pix_re = 1'b1;
                if (k_reg == 4'd0)
                    msk_re = 1'b1;
                if (k_reg == 4'd8)
                begin
                    state_next = msk_rd_reg ? mhog_pkg::ST_VEC : mhog_pkg::ST_NEXT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            mhog_pkg::ST_VEC:
            begin
                if (vec_done)
                begin
                    mag_next  = vec_res.mag;
                    prim_next = pbin[ANG_W +: BB];
                    if (frac[ANG_W-1])
                    begin
                        d_next   = frac - mhog_pkg::HALF_TURN;
                        sec_next = (pbin[ANG_W +: BB] == BB'(BINS - 1)) ? '0
                                   : pbin[ANG_W +: BB] + 1'b1;
                    end
                    else
                    begin
                        d_next   = mhog_pkg::HALF_TURN - frac;
                        sec_next = (pbin[ANG_W +: BB] == '0) ? BB'(BINS - 1)
                                   : pbin[ANG_W +: BB] - 1'b1;
                    end
                    state_next = mhog_pkg::ST_MUL;
                end
            end

            mhog_pkg::ST_MUL:
            begin
                share_next = prod[ANG_W +: MAG_W];
                side_next  = 1'b0;
                state_next = mhog_pkg::ST_BRD;
            end

            mhog_pkg::ST_BRD:
            begin
                bin_re     = 1'b1;
                state_next = mhog_pkg::ST_BWR;
            end

            mhog_pkg::ST_BWR:
            begin
                bin_we = 1'b1;
                if (!side_reg)
                begin
                    side_next  = 1'b1;
                    state_next = mhog_pkg::ST_BRD;
                end
                else
                begin
                    state_next = mhog_pkg::ST_NEXT;
                end
            end

            mhog_pkg::ST_NEXT:
            begin
                k_next = '0;
                if ((CW+1)'(pc_reg) + 1'b1 < pw_reg)
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = mhog_pkg::ST_FETCH;
                end
                else if (!final_reg)
                begin
                    old_bank_next = new_bank_reg;
                    new_bank_next = in_bank_reg;
                    in_bank_next  = old_bank_reg;
                    dm_next       = inm_reg;
                    inm_next      = dm_reg;
                    if ((RW+1)'(row_reg) + 1'b1 < h_use)
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = mhog_pkg::ST_IDLE;
                    end
                    else
                    begin
                        // bottom row mirrors the row above it
                        row_next   = '0;
                        up_next    = new_bank_reg;
                        mid_next   = in_bank_reg;
                        dn_next    = new_bank_reg;
                        pm_next    = inm_reg;
                        final_next = 1'b1;
                        pc_next    = '0;
                        state_next = mhog_pkg::ST_FETCH;
                    end
                end
                else
                begin
                    eb_next    = '0;
                    state_next = mhog_pkg::ST_EMIT_RD;
                end
            end

            mhog_pkg::ST_EMIT_RD:
            begin
                bin_re     = 1'b1;
                bin_ra     = eb_reg;
                state_next = mhog_pkg::ST_EMIT_WR;
            end

            mhog_pkg::ST_EMIT_WR:
            begin
                bin_wa = eb_reg;
                bin_wd = '0;
                if (!ov_reg || m_tready)
                begin
                    ov_next = 1'b1;
                    od_next = {{(mhog_pkg::OUT_W - VAL_W - mhog_pkg::IDX_W){1'b0}},
                               cur_val, mhog_pkg::IDX_W'(eb_reg)};
                    ol_next = (eb_reg == BB'(BINS - 1));
                    bin_we  = 1'b1;
                    if (eb_reg == BB'(BINS - 1))
                    begin
                        state_next = mhog_pkg::ST_IDLE;
                    end
                    else
                    begin
                        eb_next    = eb_reg + 1'b1;
                        state_next = mhog_pkg::ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = mhog_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mhog_pkg::ST_IDLE;
            cw_reg       <= mhog_pkg::CFG_W'(64);
            ch_reg       <= mhog_pkg::CFG_W'(64);
            col_reg      <= '0;
            row_reg      <= '0;
            in_bank_reg  <= 2'd0;
            new_bank_reg <= 2'd1;
            old_bank_reg <= 2'd2;
            inm_reg      <= 1'b0;
            dm_reg       <= 1'b1;
            up_reg       <= 2'd0;
            mid_reg      <= 2'd0;
            dn_reg       <= 2'd0;
            pm_reg       <= 1'b0;
            final_reg    <= 1'b0;
            pc_reg       <= '0;
            pw_reg       <= '0;
            k_reg        <= '0;
            side_reg     <= 1'b0;
            eb_reg       <= '0;
            ov_reg       <= 1'b0;
            bin_ok_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cw_reg       <= cw_next;
            ch_reg       <= ch_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            in_bank_reg  <= in_bank_next;
            new_bank_reg <= new_bank_next;
            old_bank_reg <= old_bank_next;
            inm_reg      <= inm_next;
            dm_reg       <= dm_next;
            up_reg       <= up_next;
            mid_reg      <= mid_next;
            dn_reg       <= dn_next;
            pm_reg       <= pm_next;
            final_reg    <= final_next;
            pc_reg       <= pc_next;
            pw_reg       <= pw_next;
            k_reg        <= k_next;
            side_reg     <= side_next;
            eb_reg       <= eb_next;
            ov_reg       <= ov_next;
            if (bin_we)
                bin_ok_reg[bin_wa] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prim_reg  <= prim_next;
        sec_reg   <= sec_next;
        d_reg     <= d_next;
        mag_reg   <= mag_next;
        share_reg <= share_next;
        od_reg    <= od_next;
        ol_reg    <= ol_next;
        if (state_reg == mhog_pkg::ST_FETCH && k_reg >= 4'd1 && k_reg <= 4'd7)
            tap_reg[3'(k_reg - 1'b1)] <= pix_rd_reg;
    end

    // line store for three rows
    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[pix_wa] <= s_tdata;
        if (pix_re)
            pix_rd_reg <= pix_mem[pix_ra];
    end

    // mask rows, incoming and delayed
    always_ff @(posedge clk)
    begin
        if (msk_we)
            msk_mem[msk_wa] <= s_tuser;
        if (msk_re)
            msk_rd_reg <= msk_mem[msk_ra];
    end

    // histogram bins
    always_ff @(posedge clk)
    begin
        if (bin_we)
            bin_mem[bin_wa] <= bin_wd;
        if (bin_re)
        begin
            bin_rd_reg  <= bin_mem[bin_ra];
            bin_rok_reg <= bin_ok_reg[bin_ra];
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;

endmodule

>>> rtl/core/mhog_chk.sv
// port-level checks of the histogram block and their binding
module mhog_chk #(
    parameter int BINS = 16
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [mhog_pkg::OUT_W-1:0] m_tdata,
    input logic                       m_tlast
);

    // a stalled word stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // a stalled word keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // the final bin carries the top bin number
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[3:0] == 4'(BINS - 1))
        else $error("last flag on wrong bin");

    // no pixel is taken while bins of a cell are still being sent
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open during emission");

endmodule

bind masked_hog_histogram mhog_chk #(.BINS(BINS)) u_mhog_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> bench/tb_masked_hog_histogram.sv
// testbench for the masked orientation histogram: random cells checked against a bin predictor
`timescale 1ns / 1ps

typedef int unsigned pix_row_t [64];

typedef struct {
    logic [3:0]  idx;
    logic [26:0] val;
    logic        last;
} bin_word_t;

// tracks the line stores and bin sums and holds the bins still to come
class bin_predictor;
    pix_row_t        older_row, newer_row, arriving_row;
    bit              mid_mask [64];
    bit              arriving_mask [64];
    int unsigned     col_cnt, row_cnt;
    longint unsigned sums [16];
    int unsigned     width_reg, height_reg;
    bin_word_t       expected_bins [$];
    int unsigned     errors;

    function new();
        foreach (older_row[i])
        begin
            older_row[i] = 0;
            newer_row[i] = 0;
            arriving_row[i] = 0;
            mid_mask[i] = 0;
            arriving_mask[i] = 0;
        end
        foreach (sums[i])
            sums[i] = 0;
        col_cnt = 0;
        row_cnt = 0;
        width_reg = 64;
        height_reg = 64;
        errors = 0;
    endfunction

    function int unsigned pending();
        return expected_bins.size();
    endfunction

    function void set_reg(logic [0:0] index, logic [6:0] value);
        if (index == mhog_pkg::REG_CELL_WIDTH)
            width_reg = value;
        else
            height_reg = value;
    endfunction

    static function int unsigned clamp(int unsigned v);
        if (v < 2)
            return 2;
        if (v > 64)
            return 64;
        return v;
    endfunction

    static function longint unsigned root(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // vectoring cordic on (-dx, -dy), angle as a turn fraction
    static function logic [15:0] heading(longint dx, longint dy);
        int unsigned steps [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                    41, 20, 10, 5, 3, 1};
        longint x, y, xs, ys;
        int unsigned z;
        x = -dx * 256;
        y = -dy * 256;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32768;
        end
        for (int i = 0; i < 14; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + steps[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - steps[i];
            end
        end
        return z[15:0];
    endfunction

    function void add_bin(int unsigned b, longint unsigned v);
        sums[b] = sums[b] + v;
        if (sums[b] > 134217727)
            sums[b] = 134217727;
    endfunction

    // gradient pass over one row
    function void sweep(pix_row_t up, pix_row_t mid, pix_row_t down, int unsigned w);
        int unsigned l, r, prim, sec, f, d;
        longint dx, dy;
        longint unsigned mag, p, share;
        for (int unsigned c = 0; c < w; c++)
        begin
            if (!mid_mask[c])
                continue;
            l = (c == 0) ? 1 : c - 1;
            r = (c + 1 < w) ? c + 1 : w - 2;
            dx = longint'(up[r] + 2 * mid[r] + down[r]) - longint'(up[l] + 2 * mid[l] + down[l]);
            dy = longint'(down[l] + 2 * down[c] + down[r]) - longint'(up[l] + 2 * up[c] + up[r]);
            mag = root(longint'(dx * dx + dy * dy) * 256);
            p = longint'(heading(dx, dy)) * 16;
            prim = (p >> 16) % 16;
            f = p & 64'hFFFF;
            if (f >= 32768)
            begin
                d = f - 32768;
                sec = (prim + 1) % 16;
            end
            else
            begin
                d = 32768 - f;
                sec = (prim + 15) % 16;
            end
            share = (mag * d) >> 16;
            add_bin(prim, mag - share);
            add_bin(sec, share);
        end
    endfunction

    function void take_pixel(logic [7:0] pix, logic m);
        int unsigned w, h, col, r;
        bin_word_t e;
        w = clamp(width_reg);
        h = clamp(height_reg);
        col = col_cnt % 64;
        r = row_cnt;
        arriving_row[col] = pix;
        arriving_mask[col] = m;
        if (col + 1 < w)
        begin
            col_cnt = col + 1;
            return;
        end
        col_cnt = 0;
        if (r == 1)
            sweep(arriving_row, newer_row, arriving_row, w);
        else if (r > 1)
            sweep(older_row, newer_row, arriving_row, w);
        older_row = newer_row;
        newer_row = arriving_row;
        mid_mask = arriving_mask;
        if (r + 1 < h)
        begin
            row_cnt = r + 1;
            return;
        end
        row_cnt = 0;
        sweep(older_row, newer_row, older_row, w);
        for (int b = 0; b < 16; b++)
        begin
            e.idx = 4'(b);
            e.val = sums[b][26:0];
            e.last = (b == 15);
            expected_bins = {expected_bins, e};
            sums[b] = 0;
        end
    endfunction

    function void check_bin(logic [3:0] idx, logic [26:0] val, logic last);
        bin_word_t e;
        if (expected_bins.size() == 0)
        begin
            $display("%0t: unexpected bin word idx %0d value %0d last %0b",
                     $time, idx, val, last);
            errors++;
            return;
        end
        e = expected_bins.pop_front();
        if (idx !== e.idx)
        begin
            $display("%0t: bin_index expected %0d actual %0d", $time, e.idx, idx);
            errors++;
        end
        if (val !== e.val)
        begin
            $display("%0t: bin_value of bin %0d expected %0d actual %0d",
                     $time, e.idx, e.val, val);
            errors++;
        end
        if (last !== e.last)
        begin
            $display("%0t: last_bin of bin %0d expected %0b actual %0b",
                     $time, e.idx, e.last, last);
            errors++;
        end
    endfunction
endclass

module tb_masked_hog_histogram;

    localparam int CYCLE_LIMIT = 1000000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // pixel
    logic        s_tuser;     // mask_bit
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // bin_index[3:0], bin_value[30:4]
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [6:0]  cfg_data;

    bin_predictor predictor;
    int unsigned  cycles;
    int unsigned  pixels_sent;
    bit           calm;
    bit           hold_req;

    masked_hog_histogram DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    // run limit
    initial
        cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("masked_hog_histogram regression: fail");
            $finish;
        end
    end

    // output word check
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            predictor.check_bin(m_tdata[3:0], m_tdata[30:4], m_tlast);
    end

    // receiver stalls, with one long hold-off on request
    initial
    begin
        bit hold_done;
        hold_done = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_tready = 1'b0;
                repeat (3000) @(negedge clk);
                hold_done = 1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge clk);
            end
            else
                m_tready = 1'b1;
        end
    end

    // one pixel word, called at a falling edge
    task automatic send_pixel(logic [7:0] pix, logic m);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = pix;
        s_tuser = m;
        do
            @(posedge clk);
        while (!s_tready);
        predictor.take_pixel(pix, m);
        pixels_sent++;
        @(negedge clk);
    endtask

    // write both sizes once the block has drained
    task automatic set_size(logic [6:0] w_raw, logic [6:0] h_raw);
        s_tvalid = 1'b0;
        while (predictor.pending() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        for (int i = 0; i < 2; i++)
        begin
            cfg_valid = 1'b1;
            cfg_index = (i == 0) ? mhog_pkg::REG_CELL_WIDTH : mhog_pkg::REG_CELL_HEIGHT;
            cfg_data = (i == 0) ? w_raw : h_raw;
            do
                @(posedge clk);
            while (!cfg_ready);
            predictor.set_reg(cfg_index, cfg_data);
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    // a whole cell: 0 noise, 1 ramp with noise, 2 flat
    task automatic send_cell(int unsigned style);
        int unsigned w, h, gx, gy, base;
        logic [7:0] pix;
        w = predictor.clamp(predictor.width_reg);
        h = predictor.clamp(predictor.height_reg);
        gx = $urandom_range(0, 60);
        gy = $urandom_range(0, 60);
        base = $urandom_range(0, 255);
        for (int unsigned r = 0; r < h; r++)
            for (int unsigned c = 0; c < w; c++)
            begin
                case (style)
                    0: pix = 8'($urandom_range(0, 255));
                    1: pix = 8'(base + gx * c + gy * r + $urandom_range(0, 3));
                    default: pix = 8'(base);
                endcase
                send_pixel(pix, $urandom_range(0, 3) != 0);
            end
    endtask

    initial
    begin
        logic [7:0] corner [4] = '{8'd0, 8'd255, 8'd255, 8'd0};
        int unsigned n;
        predictor = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = mhog_pkg::REG_CELL_WIDTH;
        cfg_data = '0;
        calm = 0;
        hold_req = 0;
        pixels_sent = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // smallest cell with extreme pixels, every pixel counted
        set_size(7'd2, 7'd2);
        foreach (corner[i])
            send_pixel(corner[i], 1'b1);
        // flat cell: zero gradient adds nothing
        set_size(7'd3, 7'd3);
        for (int i = 0; i < 9; i++)
            send_pixel(8'd255, 1'b1);
        // nothing masked: all bins zero; sizes below range clamp to 2
        set_size(7'd0, 7'd1);
        for (int i = 0; i < 4; i++)
            send_pixel(8'hA5 ^ i[7:0], 1'b0);
        // checker pattern on a 3x2 cell
        set_size(7'd3, 7'd2);
        for (int i = 0; i < 6; i++)
            send_pixel(i[0] ? 8'd255 : 8'd0, i != 2);

        // sizes at the limits, 127 clamped to 64 and 1 clamped to 2
        set_size(7'd127, 7'd2);
        send_cell(0);
        set_size(7'd1, 7'd32);
        send_cell(1);

        // long receiver hold-off while cells of one size keep coming
        set_size(7'd5, 7'd4);
        hold_req = 1;
        for (int i = 0; i < 3; i++)
            send_cell($urandom_range(0, 1));

        // random cells, mostly small
        while (pixels_sent < 310)
        begin
            if (pixels_sent > 285)
                calm = 1;
            n = $urandom_range(0, 9);
            if (n < 7)
                set_size(7'($urandom_range(2, 8)), 7'($urandom_range(2, 6)));
            else if (n == 7)
                set_size(7'($urandom_range(0, 1)), 7'($urandom_range(2, 5)));
            send_cell($urandom_range(0, 5) < 3 ? 0 : ($urandom_range(0, 4) == 0 ? 2 : 1));
        end
        s_tvalid = 1'b0;

        // drain
        while (predictor.pending() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (predictor.errors == 0 && predictor.pending() == 0)
            $display("masked_hog_histogram regression: pass");
        else
            $display("masked_hog_histogram regression: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/mhog_pkg.sv
rtl/core/mhog_vec.sv
rtl/core/masked_hog_histogram.sv
rtl/core/mhog_chk.sv
bench/tb_masked_hog_histogram.sv
